// ===== sv/stip_pkg.sv =====
`default_nettype none

package stip_pkg;

	// command codes on the cmd port
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_APPEND,
		ST_NOP,
		ST_Q_FIRST,
		ST_Q_LAST,
		ST_Q_PROBE
	} state_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TAKE,
		OP_CLEAR,
		OP_APPEND,
		OP_CHECK_FIRST,
		OP_CHECK_LAST,
		OP_PROBE
	} dp_op_t;

	// source of the reported position
	typedef enum logic [2:0] {
		RES_ZERO,
		RES_COUNT,
		RES_APPEND,
		RES_LEFT,
		RES_MID
	} res_src_t;

	typedef struct packed {
		dp_op_t   op;
		res_src_t res;
		logic     emit;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic full;
		logic key_lt;
		logic key_gt;
		logic key_eq;
		logic next_cont;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/stip_ram.sv =====
`default_nettype none

module stip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/stip_ctrl.sv =====
`default_nettype none

module stip_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         cmd,
	input  wire stip_pkg::dp_stat_t stat,
	output stip_pkg::dp_cmd_t       ctl,
	output logic                    busy
);

	import stip_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.op   = OP_NONE;
		ctl.res  = RES_ZERO;
		ctl.emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.op = OP_TAKE;
					unique case (cmd)
						CMD_CLEAR:  state_d = ST_CLEAR;
						CMD_APPEND: state_d = ST_APPEND;
						CMD_QUERY:  state_d = ST_Q_FIRST;
						default:    state_d = ST_NOP;
					endcase
				end
			end
			ST_CLEAR: begin
				ctl.op   = OP_CLEAR;
				ctl.res  = RES_ZERO;
				ctl.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_APPEND: begin
				ctl.op   = OP_APPEND;
				ctl.res  = RES_APPEND;
				ctl.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_NOP: begin
				ctl.res  = RES_COUNT;
				ctl.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_Q_FIRST: begin
				ctl.op = OP_CHECK_FIRST;
				if (stat.cnt_zero || stat.key_lt) begin
					ctl.res  = RES_ZERO;
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_Q_LAST;
				end
			end
			ST_Q_LAST: begin
				ctl.op = OP_CHECK_LAST;
				priority if (stat.key_gt) begin
					ctl.res  = RES_COUNT;
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end else if (stat.next_cont) begin
					state_d = ST_Q_PROBE;
				end else begin
					ctl.res  = RES_LEFT;
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_Q_PROBE: begin
				ctl.op = OP_PROBE;
				priority if (stat.key_eq) begin
					ctl.res  = RES_MID;
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end else if (stat.next_cont) begin
					state_d = ST_Q_PROBE;
				end else begin
					ctl.res  = RES_LEFT;
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/stip_dp.sv =====
`default_nettype none

module stip_dp #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic signed [31:0]   value,
	input  wire stip_pkg::dp_cmd_t    ctl,
	output stip_pkg::dp_stat_t        stat,
	output logic             [8:0]    position,
	output logic                      status,
	output logic                      done
);

	import stip_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	logic signed [31:0] key_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   left_q;
	logic [CNT_W-1:0]   right_q;
	logic [CNT_W-1:0]   mid_q;
	logic               done_q;
	logic [8:0]         position_q;
	logic               status_q;

	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;
	logic signed [31:0] entry;

	logic               full;
	logic [CNT_W-1:0]   last_idx;
	logic [CNT_W-1:0]   count_inc;
	logic [CNT_W-1:0]   next_l;
	logic [CNT_W-1:0]   next_r;
	logic [CNT_W-1:0]   next_m;
	logic               next_cont;
	logic [CNT_W-1:0]   res_val;
	logic [CNT_W+8:0]   res_ext;

	function automatic logic [CNT_W-1:0] midpoint(input logic [CNT_W-1:0] l,
		input logic [CNT_W-1:0] r);
		return l + ((r - l) >> 1);
	endfunction

	assign full      = (count_q == FULL_CNT);
	assign last_idx  = count_q - CNT_W'(1);
	assign count_inc = count_q + CNT_W'(1);
	assign entry     = $signed(ram_rdata);

	// probe at/above key keeps left half, below moves past mid; else whole table
	always_comb begin
		if (ctl.op == OP_PROBE) begin
			if (entry < key_q) begin
				next_l = mid_q + CNT_W'(1);
				next_r = right_q;
			end else begin
				next_l = left_q;
				next_r = mid_q;
			end
		end else begin
			next_l = '0;
			next_r = last_idx;
		end
		next_m    = midpoint(next_l, next_r);
		next_cont = (next_l < next_r);
	end

	always_comb begin
		unique case (ctl.op)
			OP_CHECK_FIRST:          ram_raddr = last_idx[AW-1:0];
			OP_CHECK_LAST, OP_PROBE: ram_raddr = next_m[AW-1:0];
			default:                 ram_raddr = '0;
		endcase
	end

	assign ram_we = (ctl.op == OP_APPEND) && !full;

	stip_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(key_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		unique case (ctl.res)
			RES_ZERO:   res_val = '0;
			RES_COUNT:  res_val = count_q;
			RES_APPEND: res_val = full ? count_q : count_inc;
			RES_LEFT:   res_val = next_l;
			RES_MID:    res_val = mid_q;
			default:    res_val = '0;
		endcase
	end

	assign res_ext = {9'd0, res_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.emit;
			if (ctl.op == OP_CLEAR) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_TAKE) begin
			key_q <= value;
		end
		if (ctl.op == OP_CHECK_LAST || ctl.op == OP_PROBE) begin
			left_q  <= next_l;
			right_q <= next_r;
			mid_q   <= next_m;
		end
		if (ctl.emit) begin
			position_q <= res_ext[8:0];
			status_q   <= (ctl.op == OP_APPEND) && full;
		end
	end

	assign stat.cnt_zero  = (count_q == '0);
	assign stat.full      = full;
	assign stat.key_lt    = (key_q < entry);
	assign stat.key_gt    = (entry < key_q);
	assign stat.key_eq    = (entry == key_q);
	assign stat.next_cont = next_cont;

	assign position = position_q;
	assign status   = status_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== sv/sorted_table_insert_position.sv =====
`default_nettype none

// sorted table with insert position lookup. a command is taken at a clock edge where start
// is high and busy is low; cmd selects clear, append or query of value, and every command
// gives exactly one item on position/status, marked by done for one cycle and registered so
// a new command can be taken while it shows. the receiver cannot stall: sample the item in
// the cycle done is high. clear, append and the unused code go through their own state
// (clear, append, nop); done rises at the edge that ends it. a query walks the first and
// last entry checks and then the binary search probes, at most ceil(log2(TABLE_DEPTH))
// probes; the single read port of the entry ram, one read per cycle, paces the search.
// entries are never checked for order, and a clear only resets the count, so old ram
// contents never reach a result. no clearing pass runs after reset.
module sorted_table_insert_position #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [1:0]  cmd,
	input  wire logic signed [31:0] value,
	output logic                    done,
	output logic             [8:0]  position,
	output logic                    status
);

	import stip_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  ctl;
	dp_stat_t stat;

	// sequencer: decodes the command, walks the boundary checks and the probe loop
	stip_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.stat  (stat),
		.ctl   (ctl),
		.busy  (busy)
	);

	// datapath: key, count, search bounds, entry ram and the result register
	stip_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (value),
		.ctl     (ctl),
		.stat    (stat),
		.position(position),
		.status  (status),
		.done    (done)
	);

`ifndef SYNTH
	// one result per command means strobes are never adjacent
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe in two consecutive cycles");

	// an accepted command always occupies the sequencer for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted but sequencer idle");

	// a dropped append is only reported when the table was full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> $past(stat.full))
		else $error("full status without a full table");

	// a result always follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding busy cycle");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import stip_pkg::*;

	localparam int TABLE_DEPTH = 256;
	// the one code the block treats as a no-op
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// cycles without an accept or a result before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	// random items; phase boundaries switch the sender's idle rate
	localparam int RANDOM_ITEMS = 600;
	localparam int PHASE2_AT = 190;
	localparam int PHASE3_AT = 480;
	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

	// one expected item on the result side
	typedef struct packed {
		logic [8:0] position;
		logic       status;
	} outcome_t;

	// shadow of the table plus the queue of outcomes still owed by the block
	class insert_position_board;
		logic signed [31:0] entries [TABLE_DEPTH];
		int count;
		int errors;
		outcome_t awaited[$];

		function new();
			count = 0;
			errors = 0;
		endfunction

		// boundary checks, then floor-midpoint search stopping at the first equal probe
		function logic [8:0] locate(logic signed [31:0] key);
			int left, right, mid;
			if (count == 0)
				return 9'd0;
			if (key < entries[0])
				return 9'd0;
			if (entries[count - 1] < key)
				return 9'(count);
			left = 0;
			right = count - 1;
			while (left < right) begin
				mid = left + (right - left) / 2;
				if (entries[mid] > key)
					right = mid;
				else if (entries[mid] < key)
					left = mid + 1;
				else
					return 9'(mid);
			end
			return 9'(left);
		endfunction

		function void note_command(logic [1:0] op, logic signed [31:0] v);
			outcome_t o;
			o.status = 1'b0;
			case (op)
			CMD_CLEAR: begin
				// clear only drops the count, stale entries stay behind
				count = 0;
				o.position = 9'd0;
			end
			CMD_APPEND: begin
				if (count < TABLE_DEPTH) begin
					entries[count] = v;
					count++;
				end else begin
					o.status = 1'b1;
				end
				o.position = 9'(count);
			end
			CMD_QUERY: o.position = locate(v);
			default: o.position = 9'(count);
			endcase
			awaited.push_back(o);
		endfunction

		function void check_result(logic [8:0] pos, logic st);
			outcome_t o;
			if (awaited.size() == 0) begin
				$error("result with nothing outstanding: position %0d status %0d", pos, st);
				errors++;
				return;
			end
			o = awaited.pop_front();
			if (pos !== o.position) begin
				$error("position mismatch: expected %0d, got %0d", o.position, pos);
				errors++;
			end
			if (st !== o.status) begin
				$error("status mismatch: expected %0d, got %0d", o.status, st);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic        [1:0]  cmd;
	logic signed [31:0] value;
	logic               done;
	logic        [8:0]  position;
	logic               status;

	insert_position_board board;
	int issued;
	int idle_pct;
	int stall_cycles = 0;

	sorted_table_insert_position #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.value   (value),
		.done    (done),
		.position(position),
		.status  (status)
	);

	always #1 clk = ~clk;

	// sample both sides at the rising edge; results are checked before a new
	// item is noted so a stray strobe never pairs with the item taken that edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				board.check_result(position, status);
			if (start === 1'b1 && busy === 1'b0)
				board.note_command(cmd, value);
		end
	end

	// hang detector: any accept or result resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// mix of extremes, a small cluster around zero and full-range words
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(9))
		0: return WORD_MIN;
		1: return WORD_MAX;
		2, 3, 4: return int'($urandom_range(40)) - 20;
		default: return $signed($urandom);
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the accept;
	// idle cycles carry junk on cmd/value with start low
	task automatic issue(input logic [1:0] op, input logic signed [31:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cmd <= 2'($urandom_range(3));
			value <= $signed($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		value <= v;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
		issued++;
	endtask

	// hold off the sender until every owed result has shown up
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	// mostly well-formed use: a clear (sometimes skipped), ascending appends with some duplicates, then lookups
	task automatic sorted_burst(input int n);
		int vals[$];
		int k;
		logic signed [31:0] target;
		for (k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(5) == 0)
				vals.push_back(vals[k - 1]);
			else
				vals.push_back(pick_word());
		end
		vals.sort();
		if ($urandom_range(7) != 0)
			issue(CMD_CLEAR, pick_word());
		foreach (vals[i])
			issue(CMD_APPEND, vals[i]);
		repeat ($urandom_range(8, 3)) begin
			case ($urandom_range(4))
			0: target = vals[$urandom_range(n - 1)];
			1: target = vals[$urandom_range(n - 1)] + 1;
			2: target = vals[$urandom_range(n - 1)] - 1;
			3: target = pick_word();
			default: target = $signed($urandom);
			endcase
			issue(CMD_QUERY, target);
		end
	endtask

	// fill past capacity so appends get dropped and a lookup can return the full count
	task automatic fill_table();
		int k;
		issue(CMD_CLEAR, 32'sd0);
		for (k = 0; k < TABLE_DEPTH + 3; k++)
			issue(CMD_APPEND, k * 4096 - 1048576);
		issue(CMD_QUERY, WORD_MAX);
		issue(CMD_QUERY, WORD_MIN);
		issue(CMD_QUERY, (TABLE_DEPTH - 1) * 4096 - 1048576);
		issue(CMD_QUERY, -32'sd1048576);
		repeat (10) begin
			if ($urandom_range(1))
				issue(CMD_QUERY, int'($urandom_range(TABLE_DEPTH - 1)) * 4096 - 1048576);
			else
				issue(CMD_QUERY, int'($urandom_range(TABLE_DEPTH * 4096)) - 1048576);
		end
		issue(CMD_APPEND, 32'sd5);
	endtask

	initial begin
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_CLEAR;
		value = 32'sd0;
		issued = 0;
		idle_pct = 23;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, extremes, duplicates, exact hits and misses
		issue(CMD_QUERY, 32'sd5);
		issue(CMD_APPEND, WORD_MIN);
		issue(CMD_APPEND, -32'sd1000);
		issue(CMD_APPEND, -32'sd1000);
		issue(CMD_APPEND, 32'sd0);
		issue(CMD_APPEND, 32'sd1);
		issue(CMD_APPEND, WORD_MAX);
		issue(CMD_QUERY, WORD_MIN);
		issue(CMD_QUERY, WORD_MAX);
		issue(CMD_QUERY, -32'sd1000);
		issue(CMD_QUERY, -32'sd999);
		issue(CMD_QUERY, WORD_MIN + 1);
		issue(CMD_QUERY, WORD_MAX - 1);
		issue(CMD_QUERY, 32'sd0);
		// unused code leaves the table alone
		issue(CMD_UNUSED, -32'sd1);
		issue(CMD_CLEAR, WORD_MAX);
		issue(CMD_QUERY, 32'sd0);
		// single entry: below, above, equal with no search loop
		issue(CMD_APPEND, 32'sd100);
		issue(CMD_QUERY, 32'sd99);
		issue(CMD_QUERY, 32'sd101);
		issue(CMD_QUERY, 32'sd100);
		// out-of-order table still follows the same probe sequence
		issue(CMD_APPEND, 32'sd5);
		issue(CMD_APPEND, -32'sd7);
		issue(CMD_APPEND, 32'sd3);
		issue(CMD_QUERY, 32'sd4);
		drain();

		// random: 23% sender idle, then 46% with a full-table pass, then none
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			if (issued >= PHASE3_AT && idle_pct != 0) begin
				drain();
				idle_pct = 0;
			end else if (issued >= PHASE2_AT && idle_pct == 23) begin
				drain();
				idle_pct = 46;
				fill_table();
			end
			case ($urandom_range(9))
			0: sorted_burst($urandom_range(64, 25));
			1, 2, 3, 4, 5, 6: sorted_burst($urandom_range(24, 1));
			7: begin
				// random commands on whatever the table holds
				repeat ($urandom_range(10, 4))
					issue(2'($urandom_range(3)), pick_word());
			end
			8: begin
				// unsorted appends followed by lookups
				repeat ($urandom_range(6, 1))
					issue(CMD_APPEND, pick_word());
				repeat ($urandom_range(4, 1))
					issue(CMD_QUERY, pick_word());
			end
			default: drain();
			endcase
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
